// File: src/hpec_pkg.sv
// Shared types and constants for the half-plane edge classifier.
// Used by hpec_cfg, hpec_proj, hpec_accum and half_plane_edge_classifier.
`timescale 1ns / 1ps

package hpec_pkg;

    localparam int PIX_W     = 8;
    localparam int FWIDTH_W  = 13;
    localparam int RHO_W     = 18;
    localparam int TRIG_W    = 16;
    localparam int OFFSET_W  = 16;
    localparam int COUNT_W   = 25;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    // Threshold in Q.14: (rho +/- offset) in Q.4 shifted left by ten
    localparam int BAND_W    = RHO_W + 1;
    localparam int THR_W     = BAND_W + 10;

    localparam logic [PIX_W-1:0]   FG_THRESHOLD = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LINE_RHO      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_COS      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LINE_SIN      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LINE_OFFSET   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SIDE_AREA = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_OVERHANG  = 3'd6;

    // Reset values of the registers
    localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST   = 13'd640;
    localparam logic [RHO_W-1:0]    LINE_RHO_RST      = 18'd0;
    localparam logic [TRIG_W-1:0]   LINE_COS_RST      = 16'd16384;
    localparam logic [TRIG_W-1:0]   LINE_SIN_RST      = 16'd0;
    localparam logic [OFFSET_W-1:0] LINE_OFFSET_RST   = 16'd320;
    localparam logic [COUNT_W-1:0]  MIN_SIDE_AREA_RST = 25'd32000;
    localparam logic [COUNT_W-1:0]  MAX_OVERHANG_RST  = 25'd150;

    typedef struct packed {
        logic        [FWIDTH_W-1:0] frame_width;
        logic signed [RHO_W-1:0]    line_rho;
        logic signed [TRIG_W-1:0]   line_cos;
        logic signed [TRIG_W-1:0]   line_sin;
        logic        [OFFSET_W-1:0] line_offset;
        logic        [COUNT_W-1:0]  min_side_area;
        logic        [COUNT_W-1:0]  max_overhang;
    } cfg_t;

    // Classified pixel handed from the projection stage to the counters
    typedef struct packed {
        logic valid;
        logic pos;
        logic neg;
        logic fg;
        logic eof;
    } side_t;

endpackage

// File: src/hpec_cfg.sv
// Configuration register file with an APB-style write/read port.
// Depends on hpec_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module hpec_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpec_pkg::APB_AW-1:0]  paddr,
    input  logic [hpec_pkg::APB_DW-1:0]  pwdata,
    output logic [hpec_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output hpec_pkg::cfg_t               cfg
);

    hpec_pkg::cfg_t                     cfg_reg;
    logic [hpec_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hpec_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write one register per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= hpec_pkg::FRAME_WIDTH_RST;
            cfg_reg.line_rho      <= hpec_pkg::LINE_RHO_RST;
            cfg_reg.line_cos      <= hpec_pkg::LINE_COS_RST;
            cfg_reg.line_sin      <= hpec_pkg::LINE_SIN_RST;
            cfg_reg.line_offset   <= hpec_pkg::LINE_OFFSET_RST;
            cfg_reg.min_side_area <= hpec_pkg::MIN_SIDE_AREA_RST;
            cfg_reg.max_overhang  <= hpec_pkg::MAX_OVERHANG_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                hpec_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= pwdata[hpec_pkg::FWIDTH_W-1:0];
                hpec_pkg::REG_LINE_RHO:
                    cfg_reg.line_rho <= pwdata[hpec_pkg::RHO_W-1:0];
                hpec_pkg::REG_LINE_COS:
                    cfg_reg.line_cos <= pwdata[hpec_pkg::TRIG_W-1:0];
                hpec_pkg::REG_LINE_SIN:
                    cfg_reg.line_sin <= pwdata[hpec_pkg::TRIG_W-1:0];
                hpec_pkg::REG_LINE_OFFSET:
                    cfg_reg.line_offset <= pwdata[hpec_pkg::OFFSET_W-1:0];
                hpec_pkg::REG_MIN_SIDE_AREA:
                    cfg_reg.min_side_area <= pwdata[hpec_pkg::COUNT_W-1:0];
                hpec_pkg::REG_MAX_OVERHANG:
                    cfg_reg.max_overhang <= pwdata[hpec_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the raw register bits
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            hpec_pkg::REG_FRAME_WIDTH:
                prdata = hpec_pkg::APB_DW'(cfg_reg.frame_width);
            hpec_pkg::REG_LINE_RHO:
                prdata = hpec_pkg::APB_DW'(unsigned'(cfg_reg.line_rho));
            hpec_pkg::REG_LINE_COS:
                prdata = hpec_pkg::APB_DW'(unsigned'(cfg_reg.line_cos));
            hpec_pkg::REG_LINE_SIN:
                prdata = hpec_pkg::APB_DW'(unsigned'(cfg_reg.line_sin));
            hpec_pkg::REG_LINE_OFFSET:
                prdata = hpec_pkg::APB_DW'(cfg_reg.line_offset);
            hpec_pkg::REG_MIN_SIDE_AREA:
                prdata = hpec_pkg::APB_DW'(cfg_reg.min_side_area);
            hpec_pkg::REG_MAX_OVERHANG:
                prdata = hpec_pkg::APB_DW'(cfg_reg.max_overhang);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: src/hpec_proj.sv
// Pixel coordinate tracking, input register and projection onto the line normal.
// Depends on hpec_pkg for cfg_t, side_t and field widths.
`timescale 1ns / 1ps

module hpec_proj #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hpec_pkg::cfg_t              cfg,
    input  logic                        advance,
    input  logic                        in_accept,
    input  logic [hpec_pkg::PIX_W-1:0]  pixel_value,
    input  logic                        end_of_frame,
    output hpec_pkg::side_t             side
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int MAXC_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int PROJ_W = MAXC_W + hpec_pkg::TRIG_W + 2;
    localparam int CMP_W  = (PROJ_W > hpec_pkg::THR_W) ? PROJ_W : hpec_pkg::THR_W;
    localparam int CI_W   = COL_W + 1;
    localparam int WCMP_W = (CI_W > hpec_pkg::FWIDTH_W) ? CI_W : hpec_pkg::FWIDTH_W;

    // Coordinates of the next pixel to arrive
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CI_W-1:0]  col_inc;
    logic             row_wrap;

    // Input register
    logic             v1_reg;
    logic             fg1_reg;
    logic             eof1_reg;
    logic [COL_W-1:0] col1_reg;
    logic [ROW_W-1:0] row1_reg;

    // Projection and thresholds
    logic signed [PROJ_W-1:0]            prod_c, prod_s, proj;
    logic signed [hpec_pkg::BAND_W-1:0]  band_hi, band_lo;
    logic signed [CMP_W-1:0]             proj_x, hi_x, lo_x;

    hpec_pkg::side_t side_reg;

    // Advance the raster position; clamp width to 1..MAX_WIDTH
    assign col_inc  = {1'b0, col_reg} + CI_W'(1);
    assign row_wrap = (WCMP_W'(col_inc) >= WCMP_W'(cfg.frame_width))
                   || (col_inc == CI_W'(MAX_WIDTH));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (end_of_frame) begin
            col_next = '0;
            row_next = '0;
        end else if (row_wrap) begin
            col_next = '0;
            if (row_reg != ROW_W'(MAX_HEIGHT - 1)) begin
                row_next = row_reg + ROW_W'(1);
            end
        end else begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Capture the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fg1_reg  <= (pixel_value >= hpec_pkg::FG_THRESHOLD);
            eof1_reg <= end_of_frame;
            col1_reg <= col_reg;
            row1_reg <= row_reg;
        end
    end

    // Project x*cos + y*sin in Q.14
    assign prod_c = $signed({1'b0, col1_reg}) * cfg.line_cos;
    assign prod_s = $signed({1'b0, row1_reg}) * cfg.line_sin;
    assign proj   = prod_c + prod_s;

    // rho +/- offset in Q.4, then scaled to Q.14
    assign band_hi = $signed({cfg.line_rho[hpec_pkg::RHO_W-1], cfg.line_rho})
                   + $signed({3'b000, cfg.line_offset});
    assign band_lo = $signed({cfg.line_rho[hpec_pkg::RHO_W-1], cfg.line_rho})
                   - $signed({3'b000, cfg.line_offset});

    assign proj_x = CMP_W'(proj);
    assign hi_x   = CMP_W'($signed({band_hi, 10'b0}));
    assign lo_x   = CMP_W'($signed({band_lo, 10'b0}));

    // Register the side decision
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (advance) begin
            side_reg.valid <= v1_reg;
            side_reg.pos   <= (proj_x > hi_x);
            side_reg.neg   <= (proj_x < lo_x);
            side_reg.fg    <= fg1_reg;
            side_reg.eof   <= eof1_reg;
        end
    end

    assign side = side_reg;

endmodule

// File: src/hpec_accum.sv
// Side area and foreground counters, edge decision and result register.
// Depends on hpec_pkg for cfg_t, side_t and the counter width.
`timescale 1ns / 1ps

module hpec_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hpec_pkg::cfg_t                cfg,
    input  hpec_pkg::side_t               side,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          edge_found,
    output logic                          rho_negated,
    output logic [hpec_pkg::COUNT_W-1:0]  positive_count,
    output logic [hpec_pkg::COUNT_W-1:0]  negative_count
);

    logic [hpec_pkg::COUNT_W-1:0] pos_area_reg, pos_area_next;
    logic [hpec_pkg::COUNT_W-1:0] neg_area_reg, neg_area_next;
    logic [hpec_pkg::COUNT_W-1:0] pos_fg_reg, pos_fg_next;
    logic [hpec_pkg::COUNT_W-1:0] neg_fg_reg, neg_fg_next;

    logic                         out_valid_reg;
    logic                         edge_reg, edge_next;
    logic                         negd_reg, negd_next;
    logic [hpec_pkg::COUNT_W-1:0] pos_cnt_reg;
    logic [hpec_pkg::COUNT_W-1:0] neg_cnt_reg;
    logic                         take;
    logic                         both_big;

    // Hold the pipe only when a frame result meets a full result register that is not being taken
    assign advance = !(side.valid && side.eof && out_valid_reg && !out_ready);
    assign take    = advance && side.valid;

    // Saturating counts including the current pixel
    always_comb begin
        pos_area_next = pos_area_reg;
        neg_area_next = neg_area_reg;
        pos_fg_next   = pos_fg_reg;
        neg_fg_next   = neg_fg_reg;
        if (side.pos) begin
            if (pos_area_reg != hpec_pkg::COUNT_MAX) pos_area_next = pos_area_reg + 1'b1;
            if (side.fg && pos_fg_reg != hpec_pkg::COUNT_MAX) pos_fg_next = pos_fg_reg + 1'b1;
        end
        if (side.neg) begin
            if (neg_area_reg != hpec_pkg::COUNT_MAX) neg_area_next = neg_area_reg + 1'b1;
            if (side.fg && neg_fg_reg != hpec_pkg::COUNT_MAX) neg_fg_next = neg_fg_reg + 1'b1;
        end
    end

    // Edge rule: positive side first, then negative side
    assign both_big = (neg_area_next > cfg.min_side_area)
                   && (pos_area_next > cfg.min_side_area);

    always_comb begin
        edge_next = 1'b0;
        negd_next = 1'b0;
        priority if (!both_big) begin
            edge_next = 1'b0;
        end else if (pos_fg_next < cfg.max_overhang) begin
            edge_next = 1'b1;
        end else if (neg_fg_next < cfg.max_overhang) begin
            edge_next = 1'b1;
            negd_next = 1'b1;
        end else begin
            edge_next = 1'b0;
        end
    end

    // Accumulate; clear at the end of each frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_area_reg <= '0;
            neg_area_reg <= '0;
            pos_fg_reg   <= '0;
            neg_fg_reg   <= '0;
        end else if (take) begin
            if (side.eof) begin
                pos_area_reg <= '0;
                neg_area_reg <= '0;
                pos_fg_reg   <= '0;
                neg_fg_reg   <= '0;
            end else begin
                pos_area_reg <= pos_area_next;
                neg_area_reg <= neg_area_next;
                pos_fg_reg   <= pos_fg_next;
                neg_fg_reg   <= neg_fg_next;
            end
        end
    end

    // Result register: load on frame end, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && side.eof) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && side.eof) begin
            edge_reg    <= edge_next;
            negd_reg    <= negd_next;
            pos_cnt_reg <= pos_area_next;
            neg_cnt_reg <= neg_area_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_found     = edge_reg;
    assign rho_negated    = negd_reg;
    assign positive_count = pos_cnt_reg;
    assign negative_count = neg_cnt_reg;

`ifndef SYNTHESIS
    a_negated_needs_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && negd_reg |-> edge_reg)
        else $error("rho_negated set without edge_found");

    a_pos_fg_within_area: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_fg_reg <= pos_area_reg)
        else $error("positive foreground count exceeds positive area");

    a_neg_fg_within_area: assert property (@(posedge aclk) disable iff (!aresetn)
        neg_fg_reg <= neg_area_reg)
        else $error("negative foreground count exceeds negative area");

    a_one_side_only: assert property (@(posedge aclk) disable iff (!aresetn)
        side.valid |-> !(side.pos && side.neg))
        else $error("pixel classified on both sides of the line");
`endif

endmodule

// File: src/half_plane_edge_classifier.sv
// A pixel marked end_of_frame shows its result on m_tvalid once it has passed the input
// register, the projection register and the result register.
// Throughput: one pixel per cycle; the pipe holds only while a frame-end pixel reaches the
// counters and the previous result still waits untaken in the result register.
// Reset: synchronous active-low aresetn restores register defaults and clears the
// raster position, all side counters and the pipeline.
`timescale 1ns / 1ps

module half_plane_edge_classifier #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpec_pkg::APB_AW-1:0]  paddr,
    input  logic [hpec_pkg::APB_DW-1:0]  pwdata,
    output logic [hpec_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // Pixel stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel_value
    input  logic                         s_tlast,   // end_of_frame
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [55:0]                  m_tdata    // [0] edge_found, [1] rho_negated,
                                                    // [26:2] positive_count,
                                                    // [51:27] negative_count, [55:52] zero
);

    hpec_pkg::cfg_t               cfg;
    hpec_pkg::side_t              side;
    logic                         advance;
    logic                         in_accept;
    logic                         edge_found;
    logic                         rho_negated;
    logic [hpec_pkg::COUNT_W-1:0] positive_count;
    logic [hpec_pkg::COUNT_W-1:0] negative_count;

    assign s_tready  = advance;
    assign in_accept = s_tvalid && advance;

    hpec_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpec_proj #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_proj (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .advance      (advance),
        .in_accept    (in_accept),
        .pixel_value  (s_tdata),
        .end_of_frame (s_tlast),
        .side         (side)
    );

    hpec_accum u_accum (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .side           (side),
        .advance        (advance),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .edge_found     (edge_found),
        .rho_negated    (rho_negated),
        .positive_count (positive_count),
        .negative_count (negative_count)
    );

    // Pack the result request
    assign m_tdata = {4'b0000, negative_count, positive_count, rho_negated, edge_found};

endmodule

// File: sim/testbench.sv
// Self-checking testbench for half_plane_edge_classifier: directed table, then random frames
// under three idle mixes, checked against a behavioral classifier. Depends on hpec_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int          CLK_HALF     = 4;
    localparam int          RASTER_W_MAX = 4096;
    localparam int          RASTER_H_MAX = 4096;
    localparam int unsigned SAT_COUNT    = 32'h1FF_FFFF;
    localparam int          PHASE_ITEMS  = 590;
    localparam int          SETTLE       = 8;
    localparam int          CYCLE_LIMIT  = 500000;

    typedef struct packed {
        bit            edge_found;
        bit            rho_negated;
        bit [24:0]     positive_count;
        bit [24:0]     negative_count;
    } frame_verdict_t;

    typedef struct packed {
        bit             typed;
        frame_verdict_t verdict;
    } frame_note_t;

    typedef enum bit {ROW_WRITE, ROW_PIXEL} row_kind_e;

    typedef struct packed {
        row_kind_e                      kind;
        logic [hpec_pkg::REG_IDX_W-1:0] reg_idx;
        logic [31:0]                    reg_val;
        logic [7:0]                     pix;
        bit                             eof;
        bit                             typed;
        frame_verdict_t                 verdict;
    } stim_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [hpec_pkg::APB_AW-1:0]   paddr    = '0;
    logic [hpec_pkg::APB_DW-1:0]   pwdata   = '0;
    logic [hpec_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;   // [7:0] pixel_value
    logic                          s_tlast  = 1'b0; // end_of_frame
    logic                          m_tvalid;
    logic                          m_tready = 1'b1;
    logic [55:0]                   m_tdata;         // [0] edge_found, [1] rho_negated,
                                                    // [26:2] positive_count,
                                                    // [51:27] negative_count

    // Register mirror
    int unsigned width_cfg;
    longint      rho_cfg;
    longint      cos_cfg;
    longint      sin_cfg;
    longint      offset_cfg;
    int unsigned min_area_cfg;
    int unsigned overhang_cfg;

    // Raster position and side counters
    int unsigned raster_col;
    int unsigned raster_row;
    int unsigned pos_area;
    int unsigned neg_area;
    int unsigned pos_fg;
    int unsigned neg_fg;

    frame_verdict_t expected_verdicts[$];
    frame_note_t    frame_notes[$];
    stim_row_t      stim_table[$];

    int send_idle_pct = 34;
    int recv_idle_pct = 64;
    int error_count   = 0;
    int cycle_count   = 0;

    half_plane_edge_classifier uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Mirror of the cleared raster position and counters
    function automatic void clear_counters();
        raster_col = 0;
        raster_row = 0;
        pos_area   = 0;
        neg_area   = 0;
        pos_fg     = 0;
        neg_fg     = 0;
    endfunction

    function automatic int unsigned bump(int unsigned c);
        return (c < SAT_COUNT) ? c + 1 : SAT_COUNT;
    endfunction

    function automatic void mirror_write(logic [hpec_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
        unique case (idx)
            hpec_pkg::REG_FRAME_WIDTH:   width_cfg    = 32'(val[hpec_pkg::FWIDTH_W-1:0]);
            hpec_pkg::REG_LINE_RHO:      rho_cfg      = longint'($signed(val[hpec_pkg::RHO_W-1:0]));
            hpec_pkg::REG_LINE_COS:      cos_cfg      = longint'($signed(val[hpec_pkg::TRIG_W-1:0]));
            hpec_pkg::REG_LINE_SIN:      sin_cfg      = longint'($signed(val[hpec_pkg::TRIG_W-1:0]));
            hpec_pkg::REG_LINE_OFFSET:   offset_cfg   = longint'(val[hpec_pkg::OFFSET_W-1:0]);
            hpec_pkg::REG_MIN_SIDE_AREA: min_area_cfg = 32'(val[hpec_pkg::COUNT_W-1:0]);
            hpec_pkg::REG_MAX_OVERHANG:  overhang_cfg = 32'(val[hpec_pkg::COUNT_W-1:0]);
            default: ;
        endcase
    endfunction

    // Project one pixel onto the line normal, count it, and judge the frame on its last pixel
    function automatic bit classify_pixel(logic [7:0] pix, bit eof, output frame_verdict_t v);
        int unsigned span;
        longint      proj;
        longint      upper;
        longint      lower;
        bit          fg;
        span  = width_cfg;
        fg    = (pix >= hpec_pkg::FG_THRESHOLD);
        v     = '0;
        if (span < 1) span = 1;
        if (span > RASTER_W_MAX) span = RASTER_W_MAX;
        proj  = longint'(raster_col) * cos_cfg + longint'(raster_row) * sin_cfg;
        upper = (rho_cfg + offset_cfg) * 1024;
        lower = (rho_cfg - offset_cfg) * 1024;
        if (proj > upper) begin
            pos_area = bump(pos_area);
            if (fg) pos_fg = bump(pos_fg);
        end
        if (proj < lower) begin
            neg_area = bump(neg_area);
            if (fg) neg_fg = bump(neg_fg);
        end
        // Advance the raster position, saturating on the last row
        if (raster_col + 1 >= span) begin
            raster_col = 0;
            if (raster_row + 1 < RASTER_H_MAX) raster_row++;
        end else begin
            raster_col++;
        end
        if (!eof) return 1'b0;
        if (neg_area > min_area_cfg && pos_area > min_area_cfg) begin
            if (pos_fg < overhang_cfg) begin
                v.edge_found = 1'b1;
            end else if (neg_fg < overhang_cfg) begin
                v.edge_found  = 1'b1;
                v.rho_negated = 1'b1;
            end
        end
        v.positive_count = pos_area[24:0];
        v.negative_count = neg_area[24:0];
        clear_counters();
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Predict on every accepted pixel request
    always @(posedge aclk) begin
        frame_verdict_t v;
        frame_note_t    note;
        if (aresetn && s_tvalid && s_tready) begin
            if (classify_pixel(s_tdata, s_tlast, v)) begin
                note = frame_notes.pop_front();
                expected_verdicts.insert(expected_verdicts.size(),
                                         note.typed ? note.verdict : v);
            end
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        frame_verdict_t v;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("result with no expectation waiting: m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                v = expected_verdicts.pop_front();
                check_field("edge_found", 32'(v.edge_found), 32'(m_tdata[0]));
                check_field("rho_negated", 32'(v.rho_negated), 32'(m_tdata[1]));
                check_field("positive_count", 32'(v.positive_count), 32'(m_tdata[26:2]));
                check_field("negative_count", 32'(v.negative_count), 32'(m_tdata[51:27]));
            end
        end
    end

    // Receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[half_plane_edge_classifier] ERROR");
            $finish;
        end
    end

    task automatic write_register(logic [hpec_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        mirror_write(idx, val);
        @(posedge aclk);
    endtask

    task automatic send_pixel(logic [7:0] pix, bit eof, bit typed, frame_verdict_t verdict);
        frame_note_t note;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        if (eof) begin
            note.typed   = typed;
            note.verdict = verdict;
            frame_notes.insert(frame_notes.size(), note);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender until every result is out and the pipe has emptied
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int signed_pick(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] pick_trig();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, 65535);
        if (r < 20) return (r < 14) ? 32'(16384) : (r < 17) ? 32'(-16384) : 32'(0);
        return 32'(signed_pick(16384));
    endfunction

    // Choose a line that mostly crosses small frames, with extremes mixed in
    task automatic pick_line_setup();
        int          r;
        logic [31:0] val;
        r = $urandom_range(0, 99);
        if (r < 80)      val = $urandom_range(1, 12);
        else if (r < 87) val = $urandom_range(13, 300);
        else if (r < 91) val = 0;
        else if (r < 95) val = RASTER_W_MAX;
        else             val = $urandom_range(RASTER_W_MAX + 1, 8191);
        write_register(hpec_pkg::REG_FRAME_WIDTH, val);
        r = $urandom_range(0, 99);
        val = (r < 85) ? 32'(signed_pick(400)) : $urandom_range(0, 32'h3FFFF);
        write_register(hpec_pkg::REG_LINE_RHO, val);
        write_register(hpec_pkg::REG_LINE_COS, pick_trig());
        write_register(hpec_pkg::REG_LINE_SIN, pick_trig());
        r = $urandom_range(0, 99);
        if (r < 20)      val = 0;
        else if (r < 90) val = $urandom_range(1, 24);
        else             val = $urandom_range(0, 65535);
        write_register(hpec_pkg::REG_LINE_OFFSET, val);
        r = $urandom_range(0, 99);
        if (r < 10)      val = 0;
        else if (r < 90) val = $urandom_range(0, 12);
        else if (r < 95) val = SAT_COUNT;
        else             val = $urandom_range(0, SAT_COUNT);
        write_register(hpec_pkg::REG_MIN_SIDE_AREA, val);
        r = $urandom_range(0, 99);
        if (r < 10)      val = 0;
        else if (r < 85) val = $urandom_range(0, 12);
        else             val = $urandom_range(0, SAT_COUNT);
        write_register(hpec_pkg::REG_MAX_OVERHANG, val);
    endtask

    function automatic logic [7:0] pick_pixel(int density);
        if ($urandom_range(0, 99) < density) return $urandom_range(128, 255);
        return $urandom_range(0, 127);
    endfunction

    // Stream one frame of random pixels; returns its length
    task automatic send_frame(output int len);
        int density;
        len     = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 60) : $urandom_range(61, 200);
        density = $urandom_range(0, 100);
        for (int i = 0; i < len; i++) begin
            send_pixel(pick_pixel(density), i == len - 1, 1'b0, '0);
        end
    endtask

    function automatic void add_write(logic [hpec_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_pixel(logic [7:0] pix, bit eof);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_PIXEL;
        row.pix  = pix;
        row.eof  = eof;
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_last(logic [7:0] pix, bit [24:0] pos_n, bit [24:0] neg_n);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_PIXEL;
        row.pix     = pix;
        row.eof     = 1'b1;
        row.typed   = 1'b1;
        row.verdict = '{1'b0, 1'b0, pos_n, neg_n};
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void build_table();
        // Lone pixel at the origin sits inside the default dead band
        add_last(8'd255, 25'd0, 25'd0);
        // Width zero clamps to one: every pixel starts a new row
        add_write(hpec_pkg::REG_FRAME_WIDTH, 32'd0);
        add_write(hpec_pkg::REG_LINE_RHO, 32'd0);
        add_write(hpec_pkg::REG_LINE_COS, 32'd0);
        add_write(hpec_pkg::REG_LINE_SIN, 32'd16384);
        add_write(hpec_pkg::REG_LINE_OFFSET, 32'd0);
        add_write(hpec_pkg::REG_MIN_SIDE_AREA, 32'd0);
        add_write(hpec_pkg::REG_MAX_OVERHANG, 32'd0);
        add_pixel(8'd128, 1'b0);
        add_pixel(8'd127, 1'b0);
        add_last(8'd255, 25'd2, 25'd0);
        // Most negative rho with widest band and clamped width: all positive
        add_write(hpec_pkg::REG_FRAME_WIDTH, 32'd8191);
        add_write(hpec_pkg::REG_LINE_RHO, 32'(-131072));
        add_write(hpec_pkg::REG_LINE_COS, 32'd16384);
        add_write(hpec_pkg::REG_LINE_SIN, 32'd0);
        add_write(hpec_pkg::REG_LINE_OFFSET, 32'd65535);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd128, 1'b0);
        add_last(8'd127, 25'd4, 25'd0);
        // Largest rho, trig beyond unity: all negative
        add_write(hpec_pkg::REG_FRAME_WIDTH, 32'd4096);
        add_write(hpec_pkg::REG_LINE_RHO, 32'd131071);
        add_write(hpec_pkg::REG_LINE_OFFSET, 32'd0);
        add_write(hpec_pkg::REG_LINE_COS, 32'h0000_8000);
        add_write(hpec_pkg::REG_LINE_SIN, 32'd32767);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd0, 1'b0);
        add_last(8'd200, 25'd0, 25'd3);
        // Vertical line at x=1: overhang on the positive side gives a negated edge
        add_write(hpec_pkg::REG_FRAME_WIDTH, 32'd4);
        add_write(hpec_pkg::REG_LINE_RHO, 32'd16);
        add_write(hpec_pkg::REG_LINE_COS, 32'd16384);
        add_write(hpec_pkg::REG_LINE_SIN, 32'd0);
        add_write(hpec_pkg::REG_MAX_OVERHANG, 32'd1);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd0, 1'b1);
        // Looser overhang: positive side wins
        add_write(hpec_pkg::REG_MAX_OVERHANG, 32'd2);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd0, 1'b1);
        // Saturated area floor: never an edge
        add_write(hpec_pkg::REG_MIN_SIDE_AREA, 32'h01FF_FFFF);
        add_last(8'd255, 25'd0, 25'd1);
    endfunction

    initial begin
        int        phase_items;
        int        len;
        bit        after_pixel;
        stim_row_t row;

        width_cfg    = 32'(hpec_pkg::FRAME_WIDTH_RST);
        rho_cfg      = longint'($signed(hpec_pkg::LINE_RHO_RST));
        cos_cfg      = longint'($signed(hpec_pkg::LINE_COS_RST));
        sin_cfg      = longint'($signed(hpec_pkg::LINE_SIN_RST));
        offset_cfg   = longint'(hpec_pkg::LINE_OFFSET_RST);
        min_area_cfg = 32'(hpec_pkg::MIN_SIDE_AREA_RST);
        overhang_cfg = 32'(hpec_pkg::MAX_OVERHANG_RST);
        clear_counters();
        build_table();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        after_pixel = 1'b0;
        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_WRITE) begin
                if (after_pixel) drain_results();
                write_register(row.reg_idx, row.reg_val);
                after_pixel = 1'b0;
            end else begin
                send_pixel(row.pix, row.eof, row.typed, row.verdict);
                after_pixel = 1'b1;
            end
        end
        drain_results();

        // Random frames under each idle mix
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 34 : 0;
            phase_items   = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick_line_setup();
                repeat ($urandom_range(1, 4)) begin
                    send_frame(len);
                    phase_items += len;
                end
                drain_results();
            end
        end

        if (error_count == 0) begin
            $display("[half_plane_edge_classifier] OK");
        end else begin
            $display("[half_plane_edge_classifier] ERROR");
        end
        $finish;
    end

endmodule
